/* rtl/core/min_tracking_stack_defines.svh */
// Assertion macros for the min tracking stack.
// Every check is clocked on i_clk and idle while i_rst_n is low.
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a condition on every rising clock edge.
`define MST_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("min_tracking_stack check failed");
// Check that the antecedent implies the consequent in the next cycle.
`define MST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("min_tracking_stack check failed");
`else
`define MST_ASSERT(lbl, cond)
`define MST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/mst_pkg.sv */
package mst_pkg;

    // Stored words carry one extra bit for the doubled value and one for
    // the subtraction, so the min encoding never overflows.
    localparam int WORD_W = 34;
    localparam int VAL_W  = 32;
    localparam int CAP_W  = 7;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [VAL_W-1:0]  t_val;

    localparam t_val             INT_MAX   = 32'sh7FFF_FFFF;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Operation selector in tuser.
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_PUSH_FULL  = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY  = 2'd2;

    // Register index on the configuration port.
    localparam logic REG_CAPACITY = 1'b0;

    // Shift command broadcast to every cell of the stack.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

/* rtl/core/mst_cell.sv */
// One stack entry. Cell 0 is the top; a push moves every word one cell
// deeper, a pop moves every word one cell toward the top.
module mst_cell (
    input  logic              i_clk,
    input  mst_pkg::t_cell_ctl i_ctl,
    input  mst_pkg::t_word    i_from_up,
    input  mst_pkg::t_word    i_from_dn,
    output mst_pkg::t_word    o_word
);

    mst_pkg::t_word r_word;

    // Shift with the rest of the chain, else hold.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_word <= i_from_up;
        end else if (i_ctl.pop) begin
            r_word <= i_from_dn;
        end
    end

    assign o_word = r_word;

endmodule

/* rtl/core/min_tracking_stack.sv */
// min_tracking_stack: LIFO of signed 32-bit values that reports its minimum.
// Input stream: s_axis_tuser selects push, pop or status query, and
// s_axis_tdata carries the value to push. Every accepted transfer yields
// exactly one result transfer on the m_axis side with the popped value,
// the minimum after the operation, empty and full flags and a status code.
// The result becomes valid in the cycle after the input transfer. Throughput is
// one item per cycle while the receiver keeps up: the chain of cells shifts
// once per operation and the top cell feeds the min encode/decode adder directly.
// The result sits in an output register; a new item is taken in the same
// cycle the held result is taken, so a stalled receiver stalls the input
// side once the register is full and nothing is lost.
// Reset (synchronous, active low) empties the stack, sets the minimum to
// the largest signed value and the capacity register to 64. Entry words are
// not cleared; only written entries are ever read.
// The APB port holds one register, capacity_limit, at address 0; it is
// clamped to 1..STACK_DEPTH and must be written only while the block idles.
`include "min_tracking_stack_defines.svh"

module min_tracking_stack #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] popped_value, [63:32] current_minimum, [64] is_empty,
    // [65] is_full, [67:66] status, [71:68] zero
    output logic [71:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W = (CNT_W > mst_pkg::CAP_W) ? CNT_W : mst_pkg::CAP_W;

    logic [mst_pkg::CAP_W-1:0] r_cap;
    logic [CNT_W-1:0]          r_count, n_count;
    mst_pkg::t_val             r_min, n_min;
    logic                      r_out_valid;
    logic [71:0]               r_out_data;

    logic                      w_cfg_wr;
    logic                      w_in_xfer;
    logic [CMP_W-1:0]          w_cap_raw, w_cap_eff, w_cnt_ext, w_ncnt_ext;
    logic                      w_full_now;
    mst_pkg::t_word            w_val34, w_min34, w_top, w_enc, w_dec, w_push_word;
    mst_pkg::t_val             w_popped;
    logic [1:0]                w_status;
    mst_pkg::t_cell_ctl        w_ctl;
    mst_pkg::t_word            w_cell [STACK_DEPTH];

    // Configuration port: single register, always ready.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[2] == mst_pkg::REG_CAPACITY);
    assign prdata   = (paddr[2] == mst_pkg::REG_CAPACITY) ?
                      {{(32 - mst_pkg::CAP_W){1'b0}}, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= mst_pkg::CAP_RESET;
        end else if (w_cfg_wr) begin
            r_cap <= pwdata[mst_pkg::CAP_W-1:0];
        end
    end

    // Clamp the capacity to 1..STACK_DEPTH.
    assign w_cap_raw = CMP_W'(r_cap);
    always_comb begin
        if (w_cap_raw == '0) begin
            w_cap_eff = CMP_W'(1);
        end else if (w_cap_raw > CMP_W'(STACK_DEPTH)) begin
            w_cap_eff = CMP_W'(STACK_DEPTH);
        end else begin
            w_cap_eff = w_cap_raw;
        end
    end
    assign w_cnt_ext  = CMP_W'(r_count);
    assign w_full_now = (w_cnt_ext >= w_cap_eff);

    // Take a new item whenever the output register frees up this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    // Min encoding arithmetic around the top cell.
    assign w_val34 = {{2{s_axis_tdata[31]}}, s_axis_tdata};
    assign w_min34 = {{2{r_min[31]}}, r_min};
    assign w_top   = w_cell[0];
    assign w_enc   = (w_val34 <<< 1) - w_min34;
    assign w_dec   = (w_min34 <<< 1) - w_top;

    // Operation decode and next state.
    always_comb begin
        n_count     = r_count;
        n_min       = r_min;
        w_push_word = w_val34;
        w_popped    = '0;
        w_status    = mst_pkg::ST_DONE;
        w_ctl       = '0;
        case (s_axis_tuser)
            mst_pkg::KIND_PUSH: begin
                if (w_full_now) begin
                    w_status = mst_pkg::ST_PUSH_FULL;
                end else begin
                    w_ctl.push = w_in_xfer;
                    n_count    = r_count + CNT_W'(1);
                    if (r_count == '0) begin
                        n_min = s_axis_tdata;
                    end else if (w_val34 < w_min34) begin
                        w_push_word = w_enc;
                        n_min       = s_axis_tdata;
                    end
                end
            end
            mst_pkg::KIND_POP: begin
                if (r_count == '0) begin
                    w_status = mst_pkg::ST_POP_EMPTY;
                end else begin
                    w_ctl.pop = w_in_xfer;
                    n_count   = r_count - CNT_W'(1);
                    if (w_top < w_min34) begin
                        w_popped = r_min;
                        n_min    = w_dec[31:0];
                    end else begin
                        w_popped = w_top[31:0];
                    end
                    if (r_count == CNT_W'(1)) begin
                        n_min = mst_pkg::INT_MAX;
                    end
                end
            end
            default: begin
                // query and the unused code leave the state alone
            end
        endcase
    end
    assign w_ncnt_ext = CMP_W'(n_count);

    // Advance the stack state on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= mst_pkg::INT_MAX;
        end else if (w_in_xfer) begin
            r_count <= n_count;
            r_min   <= n_min;
        end
    end

    // Output register: load on input transfer, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out_data <= {4'd0, w_status, (w_ncnt_ext >= w_cap_eff),
                           (n_count == '0), n_min, w_popped};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Chain of stack cells, top at index 0.
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        mst_pkg::t_word w_up, w_dn;
        if (g == 0) begin : g_top
            assign w_up = w_push_word;
        end else begin : g_mid
            assign w_up = w_cell[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign w_dn = '0;
        end else begin : g_inner
            assign w_dn = w_cell[g+1];
        end
        mst_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_from_up (w_up),
            .i_from_dn (w_dn),
            .o_word    (w_cell[g])
        );
    end

    // Checks
    `MST_ASSERT(a_count_bound, r_count <= CNT_W'(STACK_DEPTH))
    `MST_ASSERT(a_empty_min, (r_count != '0) || (r_min == mst_pkg::INT_MAX))
    `MST_ASSERT(a_empty_result, !(m_axis_tvalid && m_axis_tdata[64]) || (m_axis_tdata[63:32] == mst_pkg::INT_MAX))
    `MST_ASSERT_NEXT(a_reject_holds, w_in_xfer && (w_status != mst_pkg::ST_DONE), (r_count == $past(r_count)) && (r_min == $past(r_min)))

endmodule

/* test/tb_min_tracking_stack.sv */
`timescale 1ns / 100ps

module tb_min_tracking_stack;

    localparam int STACK_DEPTH = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_DIRECTED = 24;
    localparam int NUM_PHASES = 10;
    localparam int STALL_AFTER = 400;
    localparam int STALL_CYCLES = 250;
    localparam int MAX_PRINTS = 50;

    localparam mst_pkg::t_val INT_MIN = 32'sh8000_0000;
    // Kind value left unused by the block; it acts as a status query
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Register byte addresses: capacity at index 0, nothing at index 1
    localparam logic [2:0] ADDR_CAPACITY = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    typedef struct packed {
        mst_pkg::t_val popped;
        mst_pkg::t_val minimum;
        logic          empty;
        logic          full;
        logic [1:0]    status;
    } t_result;

    typedef struct packed {
        logic [1:0]    kind;
        mst_pkg::t_val value;
        logic          has_want;
        t_result       want;
    } t_row;

    localparam t_result NO_WANT = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] push_value
    logic [1:0]  s_axis_tuser;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [31:0] popped_value, [63:32] current_minimum, [64] is_empty,
    // [65] is_full, [67:66] status, [71:68] zero
    logic [71:0] m_axis_tdata;

    // Stack model state
    mst_pkg::t_word            stack_words [STACK_DEPTH];
    int unsigned               depth_count;
    mst_pkg::t_word            running_min;
    logic [mst_pkg::CAP_W-1:0] capacity_reg;

    t_result expected_results [$];

    int  mismatch_count;
    int  results_seen;
    int  items_sent;
    int  cycle_count;
    int  n_push_done;
    int  n_push_encoded;
    int  n_pop_done;
    int  n_pop_restored;
    int  n_rejected;
    bit  steady_run;
    int  stall_left;
    bit  stall_done;

    t_row directed_rows [NUM_DIRECTED];
    int   phase_cap   [NUM_PHASES] = '{64, 3, 1, 0, 127, 100, 2, 64, 40, 64};
    int   phase_items [NUM_PHASES] = '{200, 120, 120, 120, 250, 150, 100, 250, 250, 250};
    int   phase_push  [NUM_PHASES] = '{70, 40, 50, 50, 75, 30, 50, 50, 60, 45};

    min_tracking_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort a run that hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL min_tracking_stack");
        $finish;
    end

    // Apply one operation to the stack model and return its result
    function automatic t_result predict_op(input logic [1:0] kind,
                                           input mst_pkg::t_val value);
        t_result        r;
        int unsigned    cap;
        mst_pkg::t_word v;
        mst_pkg::t_word word;
        r = '0;
        v = mst_pkg::t_word'(value);
        cap = capacity_reg;
        if (cap < 1) cap = 1;
        if (cap > STACK_DEPTH) cap = STACK_DEPTH;
        if (kind == mst_pkg::KIND_PUSH) begin
            if (depth_count >= cap) begin
                r.status = mst_pkg::ST_PUSH_FULL;
                n_rejected++;
            end else begin
                word = v;
                if (depth_count == 0) begin
                    running_min = v;
                end else if (v < running_min) begin
                    // Encode the old minimum into the stored word
                    word = 2 * v - running_min;
                    running_min = v;
                    n_push_encoded++;
                end
                stack_words[depth_count] = word;
                depth_count++;
                n_push_done++;
            end
        end else if (kind == mst_pkg::KIND_POP) begin
            if (depth_count == 0) begin
                r.status = mst_pkg::ST_POP_EMPTY;
                n_rejected++;
            end else begin
                depth_count--;
                word = stack_words[depth_count];
                if (word < running_min) begin
                    // Encoded word: the minimum leaves, the old one comes back
                    r.popped = running_min[mst_pkg::VAL_W-1:0];
                    running_min = 2 * running_min - word;
                    n_pop_restored++;
                end else begin
                    r.popped = word[mst_pkg::VAL_W-1:0];
                end
                if (depth_count == 0) running_min = mst_pkg::t_word'(mst_pkg::INT_MAX);
                n_pop_done++;
            end
        end
        r.minimum = (depth_count == 0) ? mst_pkg::INT_MAX
                                       : running_min[mst_pkg::VAL_W-1:0];
        r.empty = (depth_count == 0);
        r.full = (depth_count >= cap);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch at result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    // Compare one result transfer against the oldest expectation
    task automatic check_result(input logic [71:0] bus);
        t_result got;
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
            return;
        end
        want = expected_results.pop_front();
        got.popped  = bus[31:0];
        got.minimum = bus[63:32];
        got.empty   = bus[64];
        got.full    = bus[65];
        got.status  = bus[67:66];
        if (got.popped !== want.popped)
            report_mismatch($sformatf("popped_value got %0d want %0d",
                got.popped, want.popped));
        if (got.minimum !== want.minimum)
            report_mismatch($sformatf("current_minimum got %0d want %0d",
                got.minimum, want.minimum));
        if (got.empty !== want.empty)
            report_mismatch($sformatf("is_empty got %b want %b", got.empty, want.empty));
        if (got.full !== want.full)
            report_mismatch($sformatf("is_full got %b want %b", got.full, want.full));
        if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (bus[71:68] !== 4'd0)
            report_mismatch($sformatf("pad bits got %b", bus[71:68]));
    endtask

    // Receive results: random stalls, one long hold-off, none in steady runs
    initial begin
        m_axis_tready <= 1'b0;
        stall_left = 0;
        stall_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
                results_seen++;
            end
            if (!stall_done && results_seen >= STALL_AFTER) begin
                stall_left = STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady_run || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    // Offer one item, hold it until the transfer, then queue its result
    task automatic send_item(input logic [1:0] kind, input mst_pkg::t_val value,
                             input logic has_want, input t_result want);
        t_result predicted;
        while (!steady_run && $urandom_range(0, 99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_op(kind, value);
        expected_results.push_back(has_want ? want : predicted);
        items_sent++;
    endtask

    // Drop valid and wait until every queued result has arrived
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Register write: setup phase, then access phase
    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CAPACITY) capacity_reg = data[mst_pkg::CAP_W-1:0];
        // Leave the bus idle before the next access
        @(posedge i_clk);
    endtask

    function automatic mst_pkg::t_val pick_value();
        case ($urandom_range(0, 9))
            0: return INT_MIN;
            1: return mst_pkg::INT_MAX;
            2, 3, 4, 5: return mst_pkg::t_val'($urandom_range(0, 64)) - 32;
            default: return mst_pkg::t_val'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_kind(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) return mst_pkg::KIND_PUSH;
        if (r < 92) return mst_pkg::KIND_POP;
        if (r < 97) return mst_pkg::KIND_QUERY;
        return KIND_UNUSED;
    endfunction

    // Directed operations under the reset capacity
    initial begin
        directed_rows = '{
            '{mst_pkg::KIND_QUERY, 32'sd0, 1'b1,
              '{32'sd0, mst_pkg::INT_MAX, 1'b1, 1'b0, mst_pkg::ST_DONE}},
            '{mst_pkg::KIND_POP, 32'sd0, 1'b1,
              '{32'sd0, mst_pkg::INT_MAX, 1'b1, 1'b0, mst_pkg::ST_POP_EMPTY}},
            '{KIND_UNUSED, 32'sh5555_5555, 1'b1,
              '{32'sd0, mst_pkg::INT_MAX, 1'b1, 1'b0, mst_pkg::ST_DONE}},
            '{mst_pkg::KIND_PUSH, mst_pkg::INT_MAX, 1'b1,
              '{32'sd0, mst_pkg::INT_MAX, 1'b0, 1'b0, mst_pkg::ST_DONE}},
            '{mst_pkg::KIND_PUSH, INT_MIN, 1'b1,
              '{32'sd0, INT_MIN, 1'b0, 1'b0, mst_pkg::ST_DONE}},
            '{mst_pkg::KIND_PUSH,  INT_MIN,        1'b0, NO_WANT},
            '{mst_pkg::KIND_PUSH,  -32'sd1,        1'b0, NO_WANT},
            '{mst_pkg::KIND_PUSH,  32'sd0,         1'b0, NO_WANT},
            '{mst_pkg::KIND_QUERY, 32'shFFFF_FFFF, 1'b0, NO_WANT},
            '{mst_pkg::KIND_POP,   32'sd0,         1'b0, NO_WANT},
            '{mst_pkg::KIND_POP,   32'sd0,         1'b0, NO_WANT},
            '{mst_pkg::KIND_POP,   32'sd0,         1'b0, NO_WANT},
            '{mst_pkg::KIND_POP,   32'sd0,         1'b0, NO_WANT},
            '{mst_pkg::KIND_POP, 32'sd0, 1'b1,
              '{mst_pkg::INT_MAX, mst_pkg::INT_MAX, 1'b1, 1'b0, mst_pkg::ST_DONE}},
            '{mst_pkg::KIND_POP, 32'sd0, 1'b1,
              '{32'sd0, mst_pkg::INT_MAX, 1'b1, 1'b0, mst_pkg::ST_POP_EMPTY}},
            '{mst_pkg::KIND_PUSH,  32'sd100,       1'b0, NO_WANT},
            '{mst_pkg::KIND_PUSH,  32'sd50,        1'b0, NO_WANT},
            '{mst_pkg::KIND_PUSH,  32'sd75,        1'b0, NO_WANT},
            '{mst_pkg::KIND_PUSH,  32'sd10,        1'b0, NO_WANT},
            '{KIND_UNUSED,         32'sd7,         1'b0, NO_WANT},
            '{mst_pkg::KIND_POP,   32'sd0,         1'b0, NO_WANT},
            '{mst_pkg::KIND_POP,   32'sd0,         1'b0, NO_WANT},
            '{mst_pkg::KIND_POP,   32'sd0,         1'b0, NO_WANT},
            '{mst_pkg::KIND_POP,   32'sd0,         1'b0, NO_WANT}
        };
    end

    // Main sequence: reset, directed table, then random phases per capacity
    initial begin
        int p;
        int i;
        mismatch_count = 0;
        results_seen = 0;
        items_sent = 0;
        n_push_done = 0;
        n_push_encoded = 0;
        n_pop_done = 0;
        n_pop_restored = 0;
        n_rejected = 0;
        steady_run = 1'b0;
        depth_count = 0;
        running_min = mst_pkg::t_word'(mst_pkg::INT_MAX);
        capacity_reg = mst_pkg::CAP_RESET;
        foreach (stack_words[k]) stack_words[k] = '0;

        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= ADDR_CAPACITY;
        pwdata        <= 32'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 32'd0;
        s_axis_tuser  <= mst_pkg::KIND_QUERY;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].kind, directed_rows[r].value,
                      directed_rows[r].has_want, directed_rows[r].want);
        drain_results();

        for (p = 0; p < NUM_PHASES; p++) begin
            // Upper data bits are outside the register and must be dropped
            write_register(ADDR_CAPACITY, ($urandom & ~32'h7F) | 32'(phase_cap[p]));
            if (p == 5) write_register(ADDR_UNMAPPED, 32'd1);
            steady_run = (p == 7);
            for (i = 0; i < phase_items[p]; i++)
                send_item(pick_kind(phase_push[p]), pick_value(), 1'b0, NO_WANT);
            drain_results();
        end
        steady_run = 1'b0;
        repeat (8) @(posedge i_clk);

        $display("covered %0d transfers: %0d pushes (%0d min-encoded), %0d pops (%0d restoring)",
                 items_sent, n_push_done, n_push_encoded, n_pop_done, n_pop_restored);
        $display("%0d rejected operations over %0d capacity settings incl. 0, 1 and 127",
                 n_rejected, NUM_PHASES + 1);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS min_tracking_stack");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     expected_results.size());
            $display("FAIL min_tracking_stack");
        end
        $finish;
    end

endmodule
